// ===== hw/rtl/hkfi_pkg.sv =====
// Shared types and constants for the HalfKP feature index extractor.
package hkfi_pkg;

    localparam int unsigned BB_W          = 64;
    localparam int unsigned SQ_W          = 6;
    localparam int unsigned KIND_W        = 3;
    localparam int unsigned IDX_W         = 16;
    localparam int unsigned FEAT_CNT_W    = 6;
    localparam int unsigned RESULTS_PER_ITEM = 32;
    localparam int unsigned RUN_W         = 5;

    localparam logic [IDX_W-1:0]  KING_STRIDE   = 16'd640;
    localparam logic [IDX_W-1:0]  SQUARE_STRIDE = 16'd10;
    localparam logic [IDX_W-1:0]  COLOR_STRIDE  = 16'd5;
    localparam logic [KIND_W-1:0] KIND_QUEEN    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN
    } hkfi_state_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic prep;
        logic emit;
    } hkfi_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic out_free;
        logic emit_last;
    } hkfi_status_t;

    // Binary index of a one-hot word.
    function automatic logic [SQ_W-1:0] onehot_index(input logic [BB_W-1:0] onehot);
        logic [SQ_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < BB_W; i++) begin
            idx = idx | ({SQ_W{onehot[i]}} & SQ_W'(i));
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/hkfi_if.sv =====
// Valid/ready channel interfaces for bitboard items and feature words.
interface hkfi_in_if;
    logic        valid;
    logic        ready;
    logic        first_of_board;
    logic [63:0] king_occupancy;
    logic [63:0] piece_bitboard;
    logic        piece_side;
    logic [2:0]  piece_kind;

    modport source (
        output valid, first_of_board, king_occupancy, piece_bitboard,
               piece_side, piece_kind,
        input  ready
    );
    modport sink (
        input  valid, first_of_board, king_occupancy, piece_bitboard,
               piece_side, piece_kind,
        output ready
    );
endinterface

interface hkfi_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] feature_index;
    logic        last_of_run;
    logic [5:0]  feature_count;
    logic        limit_reached;

    modport source (
        output valid, feature_index, last_of_run, feature_count, limit_reached,
        input  ready
    );
    modport sink (
        input  valid, feature_index, last_of_run, feature_count, limit_reached,
        output ready
    );
endinterface

// ===== hw/rtl/halfkp_feature_index_extractor_core.sv =====
// HalfKP feature index extractor: top level joining sequencer and datapath.
// An item is taken while idle and the king base is formed in the cycle that
// follows, then one feature word per cycle while the output register is free;
// an item that fails its checks yields none. The output register lets the next
// item in while a word waits.
// Reset clears the sequencer state, the feature count and the output valid flag.
module halfkp_feature_index_extractor_core #(
    parameter int unsigned MAX_ACTIVE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    hkfi_in_if.sink     items,
    hkfi_out_if.source  features
);
    import hkfi_pkg::*;

    hkfi_cmd_t    cmd;
    hkfi_status_t status;

    hkfi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .status   (status),
        .cmd      (cmd)
    );

    hkfi_dp #(
        .MAX_ACTIVE (MAX_ACTIVE)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_first_of_board (items.first_of_board),
        .in_king_occupancy (items.king_occupancy),
        .in_piece_bitboard (items.piece_bitboard),
        .in_piece_side     (items.piece_side),
        .in_piece_kind     (items.piece_kind),
        .out_ready         (features.ready),
        .out_valid         (features.valid),
        .out_feature_index (features.feature_index),
        .out_last_of_run   (features.last_of_run),
        .out_feature_count (features.feature_count),
        .out_limit_reached (features.limit_reached)
    );

    assign items.ready = cmd.in_ready;

    a_limit_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        features.valid && features.limit_reached |-> features.last_of_run)
        else $error("limit reached on a word that is not last of run");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        features.valid |-> (features.feature_index < 16'd40960))
        else $error("feature index out of range");

    a_no_emit_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !items.ready)
        else $error("word emitted while accepting items");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> features.valid)
        else $error("emitted word not presented");

endmodule

// ===== hw/rtl/hkfi_ctrl.sv =====
// Sequencer: takes an item, prepares the king base, then pops one feature per cycle while the output is free.
module hkfi_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  hkfi_pkg::hkfi_status_t status,
    output hkfi_pkg::hkfi_cmd_t    cmd
);
    import hkfi_pkg::*;

    hkfi_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.item_ok ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/hkfi_dp.sv =====
// Datapath: item registers, king base, bit popping, feature count and output word.
module hkfi_dp #(
    parameter int unsigned MAX_ACTIVE = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hkfi_pkg::hkfi_cmd_t           cmd,
    output hkfi_pkg::hkfi_status_t        status,
    input  logic                          in_first_of_board,
    input  logic [hkfi_pkg::BB_W-1:0]     in_king_occupancy,
    input  logic [hkfi_pkg::BB_W-1:0]     in_piece_bitboard,
    input  logic                          in_piece_side,
    input  logic [hkfi_pkg::KIND_W-1:0]   in_piece_kind,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [hkfi_pkg::IDX_W-1:0]    out_feature_index,
    output logic                          out_last_of_run,
    output logic [hkfi_pkg::FEAT_CNT_W-1:0] out_feature_count,
    output logic                          out_limit_reached
);
    import hkfi_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ACTIVE + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ACTIVE);

    logic [BB_W-1:0]   king_bb_reg;
    logic [BB_W-1:0]   pieces_reg;
    logic              color_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [RUN_W-1:0]  run_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_index_reg;
    logic              out_last_reg;
    logic [FEAT_CNT_W-1:0] out_count_reg;
    logic              out_limit_reg;

    logic [BB_W-1:0]   king_low;
    logic [SQ_W-1:0]   king_sq;
    logic [IDX_W-1:0]  base_next;
    logic [BB_W-1:0]   piece_low;
    logic [BB_W-1:0]   pieces_next;
    logic [SQ_W-1:0]   piece_sq;
    logic [IDX_W-1:0]  index_next;
    logic [CNT_W-1:0]  count_next;
    logic              limit_next;
    logic              last_next;

    // King square and the per-item part of the index.
    assign king_low  = king_bb_reg & (~king_bb_reg + BB_W'(1));
    assign king_sq   = onehot_index(king_low);
    assign base_next = IDX_W'(IDX_W'(king_sq) * KING_STRIDE)
                     + IDX_W'(IDX_W'(color_reg) * COLOR_STRIDE)
                     + IDX_W'(kind_reg);

    // Lowest set piece bit, then cleared for the next pop.
    assign piece_low   = pieces_reg & (~pieces_reg + BB_W'(1));
    assign pieces_next = pieces_reg & (pieces_reg - BB_W'(1));
    assign piece_sq    = onehot_index(piece_low);
    assign index_next  = base_reg + IDX_W'(IDX_W'(piece_sq) * SQUARE_STRIDE);
    assign count_next  = count_reg + CNT_W'(1);
    assign limit_next  = (count_next >= CNT_MAX);
    assign last_next   = (pieces_next == '0) || limit_next
                      || (run_reg == RUN_W'(RESULTS_PER_ITEM - 1));

    assign status.item_ok   = (king_bb_reg != '0) && (kind_reg <= KIND_QUEEN)
                           && (pieces_reg != '0) && (count_reg < CNT_MAX);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.emit_last = last_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load && in_first_of_board) begin
                count_reg <= '0;
            end else if (cmd.emit) begin
                count_reg <= count_next;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            king_bb_reg <= in_king_occupancy;
            pieces_reg  <= in_piece_bitboard;
            color_reg   <= in_piece_side;
            kind_reg    <= in_piece_kind;
            run_reg     <= '0;
        end else if (cmd.emit) begin
            pieces_reg  <= pieces_next;
            run_reg     <= run_reg + RUN_W'(1);
        end
        if (cmd.prep) begin
            base_reg <= base_next;
        end
        if (cmd.emit) begin
            out_index_reg <= index_next;
            out_last_reg  <= last_next;
            out_count_reg <= FEAT_CNT_W'({{FEAT_CNT_W{1'b0}}, count_next});
            out_limit_reg <= limit_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_feature_index = out_index_reg;
    assign out_last_of_run   = out_last_reg;
    assign out_feature_count = out_count_reg;
    assign out_limit_reached = out_limit_reg;

endmodule
